// ===== src/craft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// craft_pkg: shared types, tables and round functions
// Nibble types, S-box, nibble permutations, round constants and the
// per-round layers used by the round cells and the tweakey unit.
// ----------------------------------------------------------------------------
package craft_pkg;

	localparam int ROUNDS_MAX_DEF = 32;
	localparam int CNT_W = 6;
	localparam int RND_W = 5;
	localparam int BLK_W = 64;
	localparam logic [RND_W-1:0] LAST_ROUND = 5'd31;

	// config register indexes
	typedef enum logic [1:0] {
		REG_KEY_LO = 2'd0,
		REG_KEY_HI = 2'd1,
		REG_TWEAK  = 2'd2,
		REG_ROUNDS = 2'd3
	} cfg_reg_t;

	// element 0 is the most significant nibble
	typedef logic [0:15][3:0] nib_t;
	typedef logic [3:0][BLK_W-1:0] tk_set_t;

	typedef struct packed {
		logic valid;
		logic dec;
	} cell_ctrl_t;

	localparam logic [3:0] SBOX [16] = '{
		4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
		4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6};
	localparam logic [3:0] PERM_P [16] = '{
		4'hf, 4'hc, 4'hd, 4'he, 4'ha, 4'h9, 4'h8, 4'hb,
		4'h6, 4'h5, 4'h4, 4'h7, 4'h1, 4'h2, 4'h3, 4'h0};
	localparam logic [3:0] PERM_Q [16] = '{
		4'hc, 4'ha, 4'hf, 4'h5, 4'he, 4'h8, 4'h9, 4'h2,
		4'hb, 4'h3, 4'h7, 4'h4, 4'h6, 4'h0, 4'h1, 4'hd};
	localparam logic [3:0] RC3 [32] = '{
		4'h1, 4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1,
		4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4,
		4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2,
		4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2, 4'h5};
	localparam logic [3:0] RC4 [32] = '{
		4'h1, 4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb,
		4'h5, 4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1,
		4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb, 4'h5,
		4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1, 4'h8};

	// MixColumn, its own inverse
	function automatic nib_t mix_col(nib_t s);
		nib_t r;
		r = s;
		for (int i = 0; i < 4; i++) begin
			r[i] = s[i] ^ s[i+8] ^ s[i+12];
			r[i+4] = s[i+4] ^ s[i+12];
		end
		return r;
	endfunction

	// round tweakey and round constants
	function automatic nib_t add_key(nib_t s, logic [BLK_W-1:0] tk, logic [RND_W-1:0] rr);
		nib_t r;
		r = s ^ nib_t'(tk);
		r[4] = r[4] ^ RC4[rr];
		r[5] = r[5] ^ RC3[rr];
		return r;
	endfunction

	// forward P: nibble i moves to place P[i]
	function automatic nib_t perm_fwd(nib_t s);
		nib_t r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			r[PERM_P[i]] = s[i];
		end
		return r;
	endfunction

	// inverse P: place i takes nibble P[i]
	function automatic nib_t perm_inv(nib_t s);
		nib_t r;
		for (int i = 0; i < 16; i++) begin
			r[i] = s[PERM_P[i]];
		end
		return r;
	endfunction

	function automatic nib_t sub_nib(nib_t s);
		nib_t r;
		for (int i = 0; i < 16; i++) begin
			r[i] = SBOX[s[i]];
		end
		return r;
	endfunction

	function automatic nib_t perm_tweak(nib_t s);
		nib_t r;
		for (int i = 0; i < 16; i++) begin
			r[i] = s[PERM_Q[i]];
		end
		return r;
	endfunction

endpackage

// ===== src/craft_tweakey.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// craft_tweakey: configuration registers and round tweakeys
// Holds the key halves, tweak and round count, and derives the four round
// tweakeys and the effective round count seen by every round cell.
// ----------------------------------------------------------------------------
module craft_tweakey import craft_pkg::*; #(
	parameter int MAX_ROUNDS = ROUNDS_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [BLK_W-1:0] cfg_data,
	output tk_set_t          tk,
	output logic [CNT_W-1:0] nr
);

	localparam logic [CNT_W-1:0] MAX_NR = CNT_W'(MAX_ROUNDS);

	logic [BLK_W-1:0] key_lo_q, key_hi_q, tweak_q;
	logic [CNT_W-1:0] rounds_q;
	logic [BLK_W-1:0] tweak_qp;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			tweak_q  <= '0;
			rounds_q <= MAX_NR;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_LO: key_lo_q <= cfg_data;
				REG_KEY_HI: key_hi_q <= cfg_data;
				REG_TWEAK:  tweak_q  <= cfg_data;
				REG_ROUNDS: rounds_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// derive tweakeys from the stored key and tweak
	always_comb begin
		tweak_qp = BLK_W'(perm_tweak(nib_t'(tweak_q)));
		tk[0] = key_lo_q ^ tweak_q;
		tk[1] = key_hi_q ^ tweak_q;
		tk[2] = key_lo_q ^ tweak_qp;
		tk[3] = key_hi_q ^ tweak_qp;
	end

	// clamp round count
	assign nr = (rounds_q > MAX_NR) ? MAX_NR : rounds_q;

endmodule

// ===== src/craft_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// craft_cell: one round cell of the cipher chain
// Applies one encryption or decryption round to the word it receives and
// hands the result to the next cell; passes the word through when its
// round lies beyond the configured count.
// ----------------------------------------------------------------------------
module craft_cell import craft_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [CNT_W-1:0] nr,
	input  tk_set_t          tk,
	input  cell_ctrl_t       ctrl_in,
	input  logic [BLK_W-1:0] data_in,
	output cell_ctrl_t       ctrl_out,
	output logic [BLK_W-1:0] data_out
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

	cell_ctrl_t       ctrl_q;
	logic [BLK_W-1:0] data_q;
	logic             active;
	logic [CNT_W-1:0] back_idx;
	logic [RND_W-1:0] rr;
	nib_t             s_in, s_enc, s_dec;
	logic [BLK_W-1:0] data_nxt;

	// pick the round this cell applies
	always_comb begin
		active   = IDX < nr;
		back_idx = nr - IDX - CNT_W'(1);
		rr       = ctrl_in.dec ? back_idx[RND_W-1:0] : IDX[RND_W-1:0];
	end

	// round function, both directions
	always_comb begin
		s_in  = nib_t'(data_in);
		s_enc = add_key(mix_col(s_in), tk[rr[1:0]], rr);
		if (rr != LAST_ROUND) begin
			s_enc = sub_nib(perm_fwd(s_enc));
		end
		s_dec = s_in;
		if (rr != LAST_ROUND) begin
			s_dec = perm_inv(sub_nib(s_dec));
		end
		s_dec = mix_col(add_key(s_dec, tk[rr[1:0]], rr));
		if (!active) begin
			data_nxt = data_in;
		end else if (ctrl_in.dec) begin
			data_nxt = BLK_W'(s_dec);
		end else begin
			data_nxt = BLK_W'(s_enc);
		end
	end

	// advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (advance) begin
			ctrl_q <= ctrl_in;
		end
	end

	// advance word
	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= data_nxt;
		end
	end

	assign ctrl_out = ctrl_q;
	assign data_out = data_q;

endmodule

// ===== src/craft_tweakable_block_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// craft_tweakable_block_cipher_top: CRAFT 64-bit tweakable block cipher
// Encrypts or decrypts one 64-bit word per cycle, unless the result side
// stalls, through a chain of round cells.
// ----------------------------------------------------------------------------
// The block is a chain of MAX_ROUNDS round cells, one per cipher round, so it
// takes a new word every cycle unless stalled; each word passes through the
// register of every cell (fewer configured rounds only let the upper cells pass
// the word through, still registered). The whole chain moves together:
// a stalled result holds every cell, and an empty result register lets the
// chain advance. Key halves, tweak and round count may be written only while
// no word is in the chain; there is no clearing pass after reset.
module craft_tweakable_block_cipher_top import craft_pkg::*; #(
	parameter int MAX_ROUNDS = ROUNDS_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [BLK_W-1:0] cfg_data,
	input  logic             blk_valid,
	output logic             blk_stall,
	input  logic             opcode,
	input  logic [BLK_W-1:0] block_in,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [BLK_W-1:0] block_out
);

	tk_set_t          tk;
	logic [CNT_W-1:0] nr;
	logic             advance;
	cell_ctrl_t       ctrl [MAX_ROUNDS+1];
	logic [BLK_W-1:0] data [MAX_ROUNDS+1];

	craft_tweakey #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_tweakey (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tk        (tk),
		.nr        (nr)
	);

	// move the chain unless the result word is held
	assign advance   = !ctrl[MAX_ROUNDS].valid || !res_stall;
	assign blk_stall = !advance;

	assign ctrl[0].valid = blk_valid;
	assign ctrl[0].dec   = opcode;
	assign data[0]       = block_in;

	for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_cell
		craft_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.nr       (nr),
			.tk       (tk),
			.ctrl_in  (ctrl[g]),
			.data_in  (data[g]),
			.ctrl_out (ctrl[g+1]),
			.data_out (data[g+1])
		);
	end

	assign res_valid = ctrl[MAX_ROUNDS].valid;
	assign block_out = data[MAX_ROUNDS];

endmodule

// ===== dv/craft_tweakable_block_cipher_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// craft_tweakable_block_cipher_top_tb: self-checking bench for the CRAFT core
// Sends 64-bit words to encrypt and decrypt under a series of key, tweak and
// round-count settings. Each expected result is worked out in the bench and
// compared with the word that the core returns. Both sides idle and stall at
// random.
// ----------------------------------------------------------------------------

// sixteen nibbles, element 0 is the most significant
typedef bit [0:15][3:0] nibbles_t;

class cipher_scoreboard;
	// S-box, permutations P and Q, round constants; element 0 leftmost
	nibbles_t sbox_tab = 64'hcad3ebf789150246;
	nibbles_t p_tab = 64'hfcdea98b65471230;
	nibbles_t q_tab = 64'hcaf5e892b374601d;
	bit [0:31][3:0] rc3_tab = 128'h14256731425673142567314256731425;
	bit [0:31][3:0] rc4_tab = 128'h18429c6b5adef7318429c6b5adef7318;

	bit [63:0] key_lo;
	bit [63:0] key_hi;
	bit [63:0] twk;
	bit [5:0] rounds;
	bit [63:0] tweakey [4];
	bit [63:0] want_blocks [$];
	int errors;

	function new();
		key_lo = '0;
		key_hi = '0;
		twk = '0;
		rounds = 6'(craft_pkg::ROUNDS_MAX_DEF);
		errors = 0;
		derive_tweakeys();
	endfunction

	// rebuild the four round tweakeys, Q applied to the tweak for the upper two
	function void derive_tweakeys();
		nibbles_t t;
		nibbles_t tq;
		t = twk;
		for (int i = 0; i < 16; i++) begin
			tq[i] = t[q_tab[i]];
		end
		tweakey[0] = key_lo ^ twk;
		tweakey[1] = key_hi ^ twk;
		tweakey[2] = key_lo ^ tq;
		tweakey[3] = key_hi ^ tq;
	endfunction

	function void set_reg(craft_pkg::cfg_reg_t idx, bit [63:0] v);
		case (idx)
			craft_pkg::REG_KEY_LO: key_lo = v;
			craft_pkg::REG_KEY_HI: key_hi = v;
			craft_pkg::REG_TWEAK:  twk = v;
			craft_pkg::REG_ROUNDS: rounds = v[5:0];
			default: ;
		endcase
		derive_tweakeys();
	endfunction

	// counts above the maximum run the full cipher
	function int round_total();
		return (rounds > craft_pkg::ROUNDS_MAX_DEF) ? craft_pkg::ROUNDS_MAX_DEF : int'(rounds);
	endfunction

	function nibbles_t mix(nibbles_t s);
		for (int i = 0; i < 4; i++) begin
			s[i] = s[i] ^ s[i+8] ^ s[i+12];
			s[i+4] = s[i+4] ^ s[i+12];
		end
		return s;
	endfunction

	function nibbles_t add_tweakey(nibbles_t s, int r);
		s = s ^ tweakey[r % 4];
		s[4] = s[4] ^ rc4_tab[r];
		s[5] = s[5] ^ rc3_tab[r];
		return s;
	endfunction

	function bit [63:0] encipher(bit [63:0] blk);
		nibbles_t s;
		nibbles_t t;
		int nr;
		nr = round_total();
		s = blk;
		for (int r = 0; r < nr; r++) begin
			s = add_tweakey(mix(s), r);
			// the last round of the full cipher skips P and the S-box
			if (r != craft_pkg::LAST_ROUND) begin
				for (int i = 0; i < 16; i++) begin
					t[p_tab[i]] = s[i];
				end
				for (int i = 0; i < 16; i++) begin
					s[i] = sbox_tab[t[i]];
				end
			end
		end
		return s;
	endfunction

	function bit [63:0] decipher(bit [63:0] blk);
		nibbles_t s;
		nibbles_t t;
		int nr;
		nr = round_total();
		s = blk;
		for (int r = nr - 1; r >= 0; r--) begin
			if (r != craft_pkg::LAST_ROUND) begin
				for (int i = 0; i < 16; i++) begin
					t[i] = sbox_tab[s[i]];
				end
				for (int i = 0; i < 16; i++) begin
					s[i] = t[p_tab[i]];
				end
			end
			s = mix(add_tweakey(s, r));
		end
		return s;
	endfunction

	function bit [63:0] predict(bit op, bit [63:0] blk);
		return op ? decipher(blk) : encipher(blk);
	endfunction

	function void note_block(bit op, bit [63:0] blk);
		want_blocks.push_back(predict(op, blk));
	endfunction

	task report(string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	// compare a returned word with the oldest outstanding one
	task check_block(logic [63:0] got);
		bit [63:0] want;
		if (want_blocks.size() == 0) begin
			report($sformatf("block_out %h with no word outstanding", got));
		end else begin
			want = want_blocks.pop_front();
			if (got !== want) begin
				report($sformatf("block_out %h, want %h", got, want));
			end
		end
	endtask
endclass

module craft_tweakable_block_cipher_top_tb;
	import craft_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = ROUNDS_MAX_DEF + 16;
	localparam int RANDOM_WORDS = 1300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [BLK_W-1:0] cfg_data;
	logic blk_valid;
	logic blk_stall;
	logic opcode;
	logic [BLK_W-1:0] block_in;
	logic res_valid;
	logic res_stall;
	logic [BLK_W-1:0] block_out;

	cipher_scoreboard sb = new();
	bit steady;
	int unsigned cycles = 0;

	craft_tweakable_block_cipher_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.blk_valid(blk_valid),
		.blk_stall(blk_stall),
		.opcode(opcode),
		.block_in(block_in),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.block_out(block_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// end a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("craft_tweakable_block_cipher_top_tb: done, errors");
			$finish;
		end
	end

	// idle cycles before a word; none while steady
	function automatic int unsigned draw_wait();
		if (steady || $urandom_range(0, 2) != 0) begin
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pick_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return rand_word();
		endcase
	endfunction

	// mostly legal counts, sometimes zero, the maximum or beyond it
	function automatic logic [63:0] pick_rounds();
		logic [63:0] v;
		v = rand_word();
		case ($urandom_range(0, 7))
			0: v[5:0] = 6'd0;
			1: v[5:0] = 6'd1;
			2: v[5:0] = 6'(ROUNDS_MAX_DEF);
			3: v[5:0] = 6'($urandom_range(ROUNDS_MAX_DEF + 1, 63));
			default: v[5:0] = 6'($urandom_range(1, ROUNDS_MAX_DEF));
		endcase
		// upper data bits are don't-care for the round count
		if ($urandom_range(0, 3) != 0) begin
			v[63:6] = '0;
		end
		return v;
	endfunction

	task write_reg(cfg_reg_t idx, logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// present one word and hold it until accepted
	task send_word(logic op, logic [63:0] blk);
		int unsigned gap;
		gap = draw_wait();
		if (gap != 0) begin
			blk_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blk_valid <= 1'b1;
		opcode <= op;
		block_in <= blk;
		do @(posedge clk); while (blk_stall);
		sb.note_block(op, blk);
	endtask

	// encrypt a word, then decrypt the ciphertext it should give
	task roundtrip(logic [63:0] blk);
		send_word(1'b0, blk);
		send_word(1'b1, sb.predict(1'b0, blk));
	endtask

	// drop valid and wait for every outstanding word
	task drain();
		blk_valid <= 1'b0;
		do @(posedge clk); while (sb.want_blocks.size() != 0);
	endtask

	task load_setting();
		write_reg(REG_KEY_LO, pick_key());
		write_reg(REG_KEY_HI, pick_key());
		write_reg(REG_TWEAK, pick_key());
		write_reg(REG_ROUNDS, pick_rounds());
	endtask

	// result side: random stall, then take one word
	initial begin
		int unsigned hold;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_wait();
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			sb.check_block(block_out);
		end
	end

	initial begin
		int words;
		int len;
		int n;
		logic [63:0] junk;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_LO;
		cfg_data = '0;
		blk_valid = 1'b0;
		opcode = 1'b0;
		block_in = '0;
		steady = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: zero key and tweak, full rounds
		send_word(1'b0, '0);
		send_word(1'b0, '1);
		send_word(1'b1, '0);
		send_word(1'b1, '1);
		send_word(1'b0, 64'h0123456789abcdef);
		send_word(1'b1, 64'h8000000000000001);
		drain();

		// all-ones key halves and tweak
		write_reg(REG_KEY_LO, '1);
		write_reg(REG_KEY_HI, '1);
		write_reg(REG_TWEAK, '1);
		steady = 1'b0;
		roundtrip(64'haaaaaaaaaaaaaaaa);
		roundtrip(64'h5555555555555555);
		drain();

		// zero rounds pass the word through
		write_reg(REG_KEY_LO, rand_word());
		write_reg(REG_KEY_HI, rand_word());
		write_reg(REG_TWEAK, rand_word());
		write_reg(REG_ROUNDS, '0);
		send_word(1'b0, rand_word());
		send_word(1'b1, rand_word());
		drain();

		// single round
		write_reg(REG_ROUNDS, 64'd1);
		roundtrip(rand_word());
		drain();

		// count beyond the maximum, junk in the upper data bits
		junk = rand_word();
		junk[5:0] = 6'd63;
		write_reg(REG_ROUNDS, junk);
		roundtrip(rand_word());
		drain();

		// one short of the full cipher: the last round still permutes
		write_reg(REG_ROUNDS, 64'd31);
		roundtrip(rand_word());
		drain();

		// random phases, each under a fresh setting
		words = 0;
		while (words < RANDOM_WORDS) begin
			load_setting();
			steady = ($urandom_range(0, 3) == 0);
			len = $urandom_range(40, 200);
			n = 0;
			while (n < len && words < RANDOM_WORDS) begin
				// hold off mid-phase until the chain empties
				if (n == len / 2 && $urandom_range(0, 1) == 1) begin
					drain();
				end
				if ($urandom_range(0, 3) == 0) begin
					roundtrip(rand_word());
					words += 2;
				end else begin
					send_word(1'($urandom_range(0, 1)), rand_word());
					words++;
				end
				if ($urandom_range(0, 29) == 0) begin
					steady = !steady;
				end
				n++;
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.want_blocks.size() == 0) begin
			$display("craft_tweakable_block_cipher_top_tb: done, clean");
		end else begin
			$display("craft_tweakable_block_cipher_top_tb: done, errors");
		end
		$finish;
	end

endmodule
